// ===== hdl/mts_pkg.sv =====
// Shared types and constants for the min-tracking stack.
// No dependencies; imported by mts_core and min_tracking_stack.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

	localparam int DEPTH   = 256;
	localparam int DATA_W  = 32;
	localparam int ENTRY_W = DATA_W + 2;
	localparam int CNT_W   = 9;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int STAT_W  = 2;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(256);
	localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic                     is_pop;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] popped;
		logic signed [DATA_W-1:0] cur_min;
		logic [CNT_W-1:0]         count;
		status_t                  status;
	} res_t;

endpackage

`default_nettype wire

// ===== hdl/mts_core.sv =====
// Stack state: top-of-stack and next-below registers, entry memory, count, minimum.
// Depends on mts_pkg. Result is combinational from the request and current state.
`timescale 1ns / 1ps
`default_nettype none

module mts_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       fire,
	input  wire mts_pkg::req_t              req,
	input  wire logic [mts_pkg::CNT_W-1:0]  cap,
	output mts_pkg::res_t                   res
);
	import mts_pkg::*;

	// entries 0 .. count-2 live in mem; the top entry sits in top_q,
	// the one below it in below_q
	logic signed [ENTRY_W-1:0] mem [DEPTH];
	logic signed [ENTRY_W-1:0] top_q;
	logic signed [ENTRY_W-1:0] below_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [DATA_W-1:0]  min_q;

	logic [CNT_W-1:0]          eff_cap;
	logic                      push_ok;
	logic                      pop_ok;
	logic                      wr_en;
	logic [ADDR_W-1:0]         wr_addr;
	logic [ADDR_W-1:0]         rd_addr;
	logic [CNT_W-1:0]          cnt_m1;
	logic [CNT_W-1:0]          cnt_m3;
	logic signed [ENTRY_W-1:0] v_ext;
	logic signed [ENTRY_W-1:0] min_ext;
	logic signed [ENTRY_W-1:0] enc;
	logic signed [ENTRY_W-1:0] restored;
	logic                      v_below;
	logic                      e_below;
	logic signed [DATA_W-1:0]  min_nxt;
	logic [CNT_W-1:0]          cnt_nxt;

	always_comb begin
		eff_cap  = (cap > CNT_DEPTH) ? CNT_DEPTH : cap;
		push_ok  = !req.is_pop && (cnt_q < eff_cap);
		pop_ok   = req.is_pop && (cnt_q != '0);
		cnt_m1   = cnt_q - CNT_W'(1);
		cnt_m3   = cnt_q - CNT_W'(3);
		wr_addr  = cnt_m1[ADDR_W-1:0];
		rd_addr  = cnt_m3[ADDR_W-1:0];
		wr_en    = push_ok && (cnt_q != '0);

		v_ext    = ENTRY_W'(req.value);
		min_ext  = ENTRY_W'(min_q);
		v_below  = req.value < min_q;
		e_below  = top_q < min_ext;
		// encoded entry marks a new minimum: 2*v - min
		enc      = (v_ext <<< 1) - min_ext;
		// previous minimum recovered from the encoded entry: 2*min - e
		restored = (min_ext <<< 1) - top_q;

		res.popped = '0;
		res.status = ST_OK;
		min_nxt    = min_q;
		cnt_nxt    = cnt_q;
		if (!req.is_pop) begin
			if (!push_ok) begin
				res.status = ST_OVERFLOW;
			end else begin
				if (cnt_q == '0 || v_below) begin
					min_nxt = req.value;
				end
				cnt_nxt = cnt_q + CNT_W'(1);
			end
		end else begin
			if (!pop_ok) begin
				res.status = ST_UNDERFLOW;
			end else begin
				cnt_nxt = cnt_m1;
				if (e_below) begin
					res.popped = min_q;
					min_nxt    = restored[DATA_W-1:0];
				end else begin
					res.popped = top_q[DATA_W-1:0];
				end
			end
		end
		res.cur_min = min_nxt;
		res.count   = cnt_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			min_q <= '0;
		end else if (fire) begin
			cnt_q <= cnt_nxt;
			min_q <= min_nxt;
		end
	end

	// payload and memory, no reset
	always_ff @(posedge clk) begin
		if (fire) begin
			if (wr_en) begin
				mem[wr_addr] <= top_q;
			end
			if (push_ok) begin
				below_q <= top_q;
				top_q   <= (cnt_q == '0 || !v_below) ? v_ext : enc;
			end else if (pop_ok) begin
				below_q <= mem[rd_addr];
				top_q   <= below_q;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/min_tracking_stack.sv =====
// Top level: stream ports, capacity, input and result registers. Needs mts_pkg, mts_core.
// Each accepted input beat goes through the request register, then the result register.
// Throughput: one beat per cycle unless the master side stalls; the top entry and the one
// below it are held in registers, so each request reads at most one memory word, registered.
// Reset (arst_n low, asynchronous): empty stack, minimum 0, capacity 256.
// The entry memory is not cleared; only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module min_tracking_stack (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] push_value
	input  wire logic        s_axis_tuser,  // [0] req_type (0 push, 1 pop)
	// result channel
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [79:0]      m_axis_tdata,  // [31:0] popped_value, [63:32] current_min,
	                                        // [72:64] entry_count, [79:73] zero
	output logic [1:0]       m_axis_tuser,  // [1:0] status
	// capacity write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [8:0]  cfg_data
);
	import mts_pkg::*;

	logic [CNT_W-1:0] cap_q;
	logic             req_v_s1;
	req_t             req_s1;
	logic             res_v_s2;
	res_t             res_s2;
	res_t             res_c;
	logic             advance;
	logic             fire;

	// capacity writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// result slot free or draining this cycle -> the request stage moves
	assign advance       = !res_v_s2 || m_axis_tready;
	assign fire          = req_v_s1 && advance;
	assign s_axis_tready = !req_v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_v_s1 <= 1'b0;
			res_v_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				req_v_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				res_v_s2 <= req_v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1.is_pop <= s_axis_tuser;
			req_s1.value  <= s_axis_tdata;
		end
		if (fire) begin
			res_s2 <= res_c;
		end
	end

	mts_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.cap    (cap_q),
		.res    (res_c)
	);

	assign m_axis_tvalid = res_v_s2;
	assign m_axis_tdata  = {7'b0, res_s2.count, res_s2.cur_min, res_s2.popped};
	assign m_axis_tuser  = res_s2.status;

endmodule

`default_nettype wire
